FILE: design/lcfp_pkg.sv
// Shared constants for the LED command frame parser.
`timescale 1ns / 1ps
package lcfp_pkg;
	localparam int MAX_PAYLOAD = 24;
	localparam int LED_COUNT   = 8;
	localparam int LED_AW      = 3;
	localparam int STORE_DEPTH = 32;
	localparam int STORE_AW    = 5;
	localparam int COLOR_W     = 24;

	localparam logic [7:0] CHAR_BANG = 8'h21;
	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_LF   = 8'h0A;

	localparam logic [7:0] CMD_ALL_OFF = 8'h10;
	localparam logic [7:0] CMD_ALL_SET = 8'h11;
	localparam logic [7:0] CMD_ONE_SET = 8'h15;
	localparam logic [7:0] CMD_EACH    = 8'h1D;

	localparam logic [4:0] DIV_RESET = 5'd4;
endpackage

FILE: design/led_command_frame_parser.sv
// Top level: byte deframer, frame store, LED pattern store and result sequencer.
`timescale 1ns / 1ps
// LED command frame parser.
// Input channel (in_valid/in_ready, rx_byte): one serial byte per beat. Bytes
// are parsed against the frame format "!!", command, length, payload, one
// spare byte, CR or LF. Every byte goes into a 32-entry frame store RAM.
// Output channel (out_valid/out_ready): one result per beat. A good frame
// yields command, length and payload bytes (result_kind 0), then for the
// LED commands all eight LED colours in GRB (result_kind 1). final_result
// marks the last result of the terminating byte.
// Config channel (cfg_valid/cfg_ready, brightness_divisor): always ready;
// write only while idle. Zero acts as one.
// Sequence: a byte that completes no frame leaves the parser idle. At a frame
// end each forwarded byte is read, then loaded once the output register has
// emptied, each LED word likewise on readout, and each colour computed takes
// three store reads, three runs of the shared serial divider and a write-back.
// in_ready is low while results are produced; a stalled receiver holds the
// sequencer, nothing is dropped. Reset clears parser state, the LED pattern
// (through per-LED valid bits) and sets the divisor to 4. No clearing pass.
module led_command_frame_parser import lcfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       result_kind,
	output logic [7:0] frame_byte,
	output logic [2:0] led_number,
	output logic [7:0] green_level,
	output logic [7:0] red_level,
	output logic [7:0] blue_level,
	output logic       final_result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [4:0] brightness_divisor
);
	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_FRD   = 5'd1;
	localparam logic [4:0] ST_FDAT  = 5'd2;
	localparam logic [4:0] ST_CMD   = 5'd3;
	localparam logic [4:0] ST_CLR   = 5'd4;
	localparam logic [4:0] ST_IDX   = 5'd5;
	localparam logic [4:0] ST_DX    = 5'd6;
	localparam logic [4:0] ST_RR    = 5'd7;
	localparam logic [4:0] ST_RG    = 5'd8;
	localparam logic [4:0] ST_RB    = 5'd9;
	localparam logic [4:0] ST_RX    = 5'd10;
	localparam logic [4:0] ST_DST   = 5'd11;
	localparam logic [4:0] ST_DWT   = 5'd12;
	localparam logic [4:0] ST_CDONE = 5'd13;
	localparam logic [4:0] ST_WALL  = 5'd14;
	localparam logic [4:0] ST_SRD   = 5'd15;
	localparam logic [4:0] ST_SDAT  = 5'd16;

	localparam logic [LED_AW-1:0] LED_LAST = LED_AW'(LED_COUNT - 1);

	// parser state
	logic [4:0]  st_q;
	logic [4:0]  pos_q;
	logic        sync_q;
	logic [7:0]  b0_q;
	logic [7:0]  cmd_q;
	logic [7:0]  len_q;
	logic [4:0]  div_q;

	// sequencer registers
	logic [4:0]        fi_q;
	logic [LED_AW-1:0] li_q;
	logic [LED_AW-1:0] idx_q;
	logic [4:0]        base_q;
	logic [1:0]        ch_q;
	logic [7:0]        cr_q, cg_q, cb_q;
	logic [7:0]        sr_q, sg_q, sb_q;
	logic [LED_COUNT-1:0] pv_q;
	logic              pv_s1;

	// output register
	logic        ov_q;
	logic        okind_q;
	logic [7:0]  obyte_q;
	logic [2:0]  oled_q;
	logic [COLOR_W-1:0] ogrb_q;
	logic        ofin_q;

	// memories
	logic                st_we;
	logic [STORE_AW-1:0] st_raddr;
	logic [7:0]          st_rdata;
	logic                pt_we;
	logic [LED_AW-1:0]   pt_waddr;
	logic [COLOR_W-1:0]  pt_wdata;
	logic [LED_AW-1:0]   pt_raddr;
	logic [COLOR_W-1:0]  pt_rdata;

	// divider
	logic       dv_start;
	logic [7:0] dv_a;
	logic [4:0] dv_d;
	logic       dv_done;
	logic [7:0] dv_q;

	logic in_acc;
	logic show;
	logic fwd_last;
	logic each_has;

	assign in_ready  = (st_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign st_we     = in_acc;

	assign show = (cmd_q == CMD_ALL_OFF) || (cmd_q == CMD_ALL_SET) ||
		(cmd_q == CMD_ONE_SET) || (cmd_q == CMD_EACH);
	assign fwd_last = (fi_q == 5'(len_q[4:0] + 5'd1));
	// LED i gets a colour when 3*(i+1) <= len
	assign each_has = ({3'b0, (5'({2'b0, li_q} + 5'd1) * 5'd3)} <= len_q);

	assign dv_d = (div_q == 5'd0) ? 5'd1 : div_q;
	assign dv_a = (ch_q == 2'd0) ? cr_q : ((ch_q == 2'd1) ? cg_q : cb_q);
	assign dv_start = (st_q == ST_DST);

	lcfp_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (pos_q),
		.wdata (rx_byte),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	lcfp_ram #(.WIDTH(COLOR_W), .DEPTH(LED_COUNT)) u_pattern (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (pt_wdata),
		.raddr (pt_raddr),
		.rdata (pt_rdata)
	);

	lcfp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (dv_a),
		.divisor  (dv_d),
		.done     (dv_done),
		.quotient (dv_q)
	);

	// store read address per state
	always_comb begin
		case (st_q)
			ST_FRD:  st_raddr = 5'(fi_q + 5'd2);
			ST_CMD:  st_raddr = 5'd4;
			ST_RR:   st_raddr = base_q;
			ST_RG:   st_raddr = 5'(base_q + 5'd1);
			ST_RB:   st_raddr = 5'(base_q + 5'd2);
			default: st_raddr = base_q;
		endcase
	end

	// pattern writes: clears, computed colours
	always_comb begin
		pt_we    = 1'b0;
		pt_waddr = li_q;
		pt_wdata = '0;
		pt_raddr = li_q;
		case (st_q)
			ST_CLR: begin
				pt_we = 1'b1;
			end
			ST_WALL: begin
				pt_we    = 1'b1;
				pt_wdata = {sg_q, sr_q, sb_q};
			end
			ST_DX: begin
				pt_we = !each_has;
			end
			ST_CDONE: begin
				pt_we    = (cmd_q != CMD_ALL_SET);
				pt_waddr = (cmd_q == CMD_ONE_SET) ? idx_q : li_q;
				pt_wdata = {sg_q, sr_q, sb_q};
			end
			default: begin
				pt_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			pos_q  <= '0;
			sync_q <= 1'b0;
			div_q  <= DIV_RESET;
			pv_q   <= '0;
			ov_q   <= 1'b0;
			fi_q   <= '0;
			li_q   <= '0;
			ch_q   <= '0;
		end else begin
			if (cfg_valid) begin
				div_q <= brightness_divisor;
			end
			if (pt_we) begin
				pv_q[pt_waddr] <= 1'b1;
			end
			if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						pos_q <= 5'(pos_q + 5'd1);
						if (pos_q == 5'd1) begin
							sync_q <= (b0_q == CHAR_BANG) && (rx_byte == CHAR_BANG);
							if (!((b0_q == CHAR_BANG) && (rx_byte == CHAR_BANG))) begin
								pos_q <= '0;
							end
						end else if (pos_q >= 5'd2 && !sync_q) begin
							pos_q <= '0;
						end else if (pos_q == 5'd3) begin
							if (cmd_q[7:4] != 4'h1 || rx_byte > 8'(MAX_PAYLOAD)) begin
								sync_q <= 1'b0;
								pos_q  <= '0;
							end
						end else if (pos_q > 5'd3 &&
							{1'b0, pos_q} == 6'(len_q[4:0] + 5'd5)) begin
							sync_q <= 1'b0;
							pos_q  <= '0;
							if (rx_byte == CHAR_CR || rx_byte == CHAR_LF) begin
								st_q <= ST_FRD;
								fi_q <= '0;
							end
						end
					end
				end
				ST_FRD: begin
					if (!ov_q) begin
						st_q <= ST_FDAT;
					end
				end
				ST_FDAT: begin
					ov_q <= 1'b1;
					fi_q <= 5'(fi_q + 5'd1);
					st_q <= fwd_last ? ST_CMD : ST_FRD;
				end
				ST_CMD: begin
					li_q <= '0;
					if (cmd_q == CMD_ALL_OFF) begin
						st_q <= ST_CLR;
					end else if (cmd_q == CMD_ALL_SET) begin
						st_q <= ST_RR;
					end else if (cmd_q == CMD_ONE_SET) begin
						st_q <= ST_IDX;
					end else if (cmd_q == CMD_EACH) begin
						st_q <= ST_DX;
					end else begin
						st_q <= ST_IDLE;
					end
				end
				ST_CLR, ST_WALL: begin
					li_q <= LED_AW'(li_q + 1'b1);
					if (li_q == LED_LAST) begin
						li_q <= '0;
						st_q <= ST_SRD;
					end
				end
				ST_IDX: begin
					if (st_rdata < 8'(LED_COUNT)) begin
						st_q <= ST_RR;
					end else begin
						st_q <= ST_SRD;
					end
				end
				ST_DX: begin
					if (each_has) begin
						st_q <= ST_RR;
					end else begin
						li_q <= LED_AW'(li_q + 1'b1);
						if (li_q == LED_LAST) begin
							li_q <= '0;
							st_q <= ST_SRD;
						end
					end
				end
				ST_RR:  st_q <= ST_RG;
				ST_RG:  st_q <= ST_RB;
				ST_RB:  st_q <= ST_RX;
				ST_RX: begin
					ch_q <= '0;
					st_q <= ST_DST;
				end
				ST_DST: st_q <= ST_DWT;
				ST_DWT: begin
					if (dv_done) begin
						ch_q <= 2'(ch_q + 2'd1);
						st_q <= (ch_q == 2'd2) ? ST_CDONE : ST_DST;
					end
				end
				ST_CDONE: begin
					if (cmd_q == CMD_ALL_SET) begin
						li_q <= '0;
						st_q <= ST_WALL;
					end else if (cmd_q == CMD_ONE_SET) begin
						li_q <= '0;
						st_q <= ST_SRD;
					end else begin
						li_q <= LED_AW'(li_q + 1'b1);
						st_q <= ST_DX;
						if (li_q == LED_LAST) begin
							li_q <= '0;
							st_q <= ST_SRD;
						end
					end
				end
				ST_SRD: begin
					if (!ov_q) begin
						st_q <= ST_SDAT;
					end
				end
				ST_SDAT: begin
					ov_q <= 1'b1;
					li_q <= LED_AW'(li_q + 1'b1);
					st_q <= ST_SRD;
					if (li_q == LED_LAST) begin
						li_q <= '0;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		pv_s1 <= pv_q[pt_raddr];
		if (in_acc) begin
			if (pos_q == 5'd0) b0_q <= rx_byte;
			if (pos_q == 5'd2) cmd_q <= rx_byte;
			if (pos_q == 5'd3) len_q <= rx_byte;
		end
		case (st_q)
			ST_CMD: begin
				if (cmd_q == CMD_ALL_SET) base_q <= 5'd4;
				if (cmd_q == CMD_ONE_SET) base_q <= 5'd5;
			end
			ST_IDX: idx_q <= st_rdata[LED_AW-1:0];
			ST_DX:  base_q <= 5'(5'd4 + 5'({2'b0, li_q} * 5'd3));
			ST_RG:  cr_q <= st_rdata;
			ST_RB:  cg_q <= st_rdata;
			ST_RX:  cb_q <= st_rdata;
			ST_DWT: begin
				if (dv_done) begin
					if (ch_q == 2'd0) sr_q <= dv_q;
					if (ch_q == 2'd1) sg_q <= dv_q;
					if (ch_q == 2'd2) sb_q <= dv_q;
				end
			end
			ST_FDAT: begin
				okind_q <= 1'b0;
				obyte_q <= st_rdata;
				oled_q  <= '0;
				ogrb_q  <= '0;
				ofin_q  <= fwd_last && !show;
			end
			ST_SDAT: begin
				okind_q <= 1'b1;
				obyte_q <= '0;
				oled_q  <= li_q;
				ogrb_q  <= pv_s1 ? pt_rdata : '0;
				ofin_q  <= (li_q == LED_LAST);
			end
			default: begin
				okind_q <= okind_q;
			end
		endcase
	end

	assign out_valid    = ov_q;
	assign result_kind  = okind_q;
	assign frame_byte   = obyte_q;
	assign led_number   = oled_q;
	assign green_level  = ogrb_q[23:16];
	assign red_level    = ogrb_q[15:8];
	assign blue_level   = ogrb_q[7:0];
	assign final_result = ofin_q;

	// position never runs past the longest frame
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= 5'd29) else $error("parse position out of range");

	// colour beats carry no frame byte, byte beats no colour
	a_kind_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (result_kind ? (frame_byte == 8'd0) :
		(led_number == 3'd0 && green_level == 8'd0 && red_level == 8'd0 &&
		blue_level == 8'd0))) else $error("result fields mixed");

	// the output register is never overwritten while full
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FDAT || st_q == ST_SDAT) |-> !ov_q)
		else $error("output overrun");
endmodule

FILE: design/lcfp_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module lcfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: design/lcfp_div.sv
// Restoring 8-by-5 bit divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lcfp_div import lcfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [7:0] dividend,
	input  logic [4:0] divisor,
	output logic       done,
	output logic [7:0] quotient
);
	logic       busy_q;
	logic       done_q;
	logic [2:0] cnt_q;
	logic [4:0] rem_q;
	logic [7:0] quo_q;
	logic [5:0] trial;
	logic       ge;

	assign trial = {rem_q, quo_q[7]};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 3'd7);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? 5'(trial - {1'b0, divisor}) : trial[4:0];
			quo_q <= {quo_q[6:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
